// File: design/bcd_pkg.sv
// Shared types and constants for the button click detector.
`default_nettype none

package bcd_pkg;

  // Number of buttons carried by one scan tick.
  localparam int unsigned NumButtons = 4;

  // Reset values of the configuration registers.
  localparam logic [3:0] DebounceTicksRst   = 4'd3;
  localparam logic [7:0] LongPressTicksRst  = 8'd50;
  localparam logic [7:0] ReleaseGapTicksRst = 8'd15;

  // Saturation limits of the per-button counters.
  localparam logic [7:0] TickMax  = 8'd255;
  localparam logic [1:0] PressMax = 2'd3;

  // Configuration register indexes (byte address divided by four).
  typedef enum logic [1:0] {
    REG_DEBOUNCE_TICKS    = 2'd0,
    REG_LONG_PRESS_TICKS  = 2'd1,
    REG_RELEASE_GAP_TICKS = 2'd2
  } reg_idx_t;

  // Per-button classification phase.
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_RELEASED = 2'd2
  } phase_t;

  // Event codes reported per button.
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  // One scan tick of raw levels, 0 means pressed.
  typedef struct packed {
    logic level_0;
    logic level_1;
    logic level_2;
    logic level_3;
  } in_payload_t;

  // One tick of reported events.
  typedef struct packed {
    logic [1:0] event_0;
    logic [1:0] event_1;
    logic [1:0] event_2;
    logic [1:0] event_3;
  } out_payload_t;

endpackage

`default_nettype wire

// File: design/button_click_detector.sv
// Top level of the button click detector: debounce and click classification.
// An accepted tick passes the input register and then the result register, which drives out_data.
// Throughput: one tick per cycle while the result side is ready; the state update of all buttons is one
// combinational pass between the input register and the result register.
// Reset (synchronous, active low) clears all button state to released and idle,
// empties both pipeline registers and restores the configuration defaults.
`default_nettype none

module button_click_detector (
  input  wire                         clk,
  input  wire                         rst_n,
  // Input tick channel
  input  wire                         in_valid,
  output logic                        in_ready,
  input  bcd_pkg::in_payload_t        in_data,
  // Result channel
  output logic                        out_valid,
  input  wire                         out_ready,
  output bcd_pkg::out_payload_t       out_data,
  // Configuration port
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [3:0]                  paddr,
  input  wire  [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned NB = bcd_pkg::NumButtons;

  // Configuration registers.
  logic [3:0] dbt_r;
  logic [7:0] lpt_r;
  logic [7:0] gap_r;

  // Pipeline registers.
  logic                   s1_valid_r;
  bcd_pkg::in_payload_t   s1_data_r;
  logic                   out_valid_r;
  bcd_pkg::out_payload_t  out_data_r;
  logic                   out_valid_nxt;
  bcd_pkg::out_payload_t  out_data_nxt;
  logic                   s1_adv;

  // Per-button state.
  logic            [NB-1:0] level_r;
  logic            [NB-1:0] level_nxt;
  logic [NB-1:0]     [3:0]  dcnt_r;
  logic [NB-1:0]     [3:0]  dcnt_nxt;
  bcd_pkg::phase_t          phase_r   [NB];
  bcd_pkg::phase_t          phase_nxt [NB];
  logic [NB-1:0]     [7:0]  tick_r;
  logic [NB-1:0]     [7:0]  tick_nxt;
  logic [NB-1:0]     [7:0]  tick_inc;
  logic [NB-1:0]     [1:0]  press_r;
  logic [NB-1:0]     [1:0]  press_nxt;
  logic [NB-1:0]     [4:0]  dsum;
  logic            [NB-1:0] raw;
  bcd_pkg::event_t          ev [NB];

  logic cfg_wr;

  // Configuration writes complete in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbt_r <= bcd_pkg::DebounceTicksRst;
      lpt_r <= bcd_pkg::LongPressTicksRst;
      gap_r <= bcd_pkg::ReleaseGapTicksRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        bcd_pkg::REG_DEBOUNCE_TICKS:    dbt_r <= pwdata[3:0];
        bcd_pkg::REG_LONG_PRESS_TICKS:  lpt_r <= pwdata[7:0];
        bcd_pkg::REG_RELEASE_GAP_TICKS: gap_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[3:2])
      bcd_pkg::REG_DEBOUNCE_TICKS:    prdata = {28'd0, dbt_r};
      bcd_pkg::REG_LONG_PRESS_TICKS:  prdata = {24'd0, lpt_r};
      bcd_pkg::REG_RELEASE_GAP_TICKS: prdata = {24'd0, gap_r};
      default:                        prdata = 32'd0;
    endcase
  end

  // Handshake: the input register advances whenever the result register is free
  // or being emptied in the same cycle.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // Raw levels of the registered tick as a vector.
  assign raw[0] = s1_data_r.level_0;
  assign raw[1] = s1_data_r.level_1;
  assign raw[2] = s1_data_r.level_2;
  assign raw[3] = s1_data_r.level_3;

  // Next state of each button: tick counter, debouncer and phase machine.
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      // Tick counter runs while not idle, saturating.
      if ((phase_r[b] != bcd_pkg::PH_IDLE) && (tick_r[b] != bcd_pkg::TickMax)) begin
        tick_inc[b] = tick_r[b] + 8'd1;
      end else begin
        tick_inc[b] = tick_r[b];
      end

      // Debounce: accept the new level after enough differing samples.
      dsum[b] = {1'b0, dcnt_r[b]} + 5'd1;
      if (level_r[b] != raw[b]) begin
        if (dsum[b] >= {1'b0, dbt_r}) begin
          level_nxt[b] = raw[b];
          dcnt_nxt[b]  = 4'd0;
        end else begin
          level_nxt[b] = level_r[b];
          dcnt_nxt[b]  = dsum[b][3:0];
        end
      end else begin
        level_nxt[b] = level_r[b];
        dcnt_nxt[b]  = 4'd0;
      end

      // Phase machine.
      phase_nxt[b] = phase_r[b];
      tick_nxt[b]  = tick_inc[b];
      press_nxt[b] = press_r[b];
      unique case (phase_r[b])
        bcd_pkg::PH_PRESSED: begin
          if (level_nxt[b]) begin
            tick_nxt[b]  = 8'd0;
            phase_nxt[b] = bcd_pkg::PH_RELEASED;
          end else if (tick_inc[b] >= lpt_r) begin
            tick_nxt[b]  = 8'd0;
            press_nxt[b] = 2'd0;
          end
        end
        bcd_pkg::PH_RELEASED: begin
          if (tick_inc[b] > gap_r) begin
            phase_nxt[b] = bcd_pkg::PH_IDLE;
          end else if (!level_nxt[b]) begin
            if (press_r[b] != bcd_pkg::PressMax) begin
              press_nxt[b] = press_r[b] + 2'd1;
            end
            phase_nxt[b] = bcd_pkg::PH_PRESSED;
            tick_nxt[b]  = 8'd0;
          end
        end
        default: begin
          if (!level_nxt[b]) begin
            phase_nxt[b] = bcd_pkg::PH_PRESSED;
            tick_nxt[b]  = 8'd0;
            press_nxt[b] = 2'd1;
          end else begin
            phase_nxt[b] = bcd_pkg::PH_IDLE;
          end
        end
      endcase
    end
  end

  // Event output of each button's phase machine.
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      ev[b] = bcd_pkg::EV_NONE;
      unique case (phase_r[b])
        bcd_pkg::PH_PRESSED: begin
          if (!level_nxt[b] && (tick_inc[b] >= lpt_r)) begin
            ev[b] = bcd_pkg::EV_LONG;
          end
        end
        bcd_pkg::PH_RELEASED: begin
          if (tick_inc[b] > gap_r) begin
            if (press_r[b] == 2'd1) begin
              ev[b] = bcd_pkg::EV_CLICK;
            end else if (press_r[b] == 2'd2) begin
              ev[b] = bcd_pkg::EV_DOUBLE;
            end
          end
        end
        default: ev[b] = bcd_pkg::EV_NONE;
      endcase
    end
  end

  // Button state advances with each tick that moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NB; b++) begin
        level_r[b] <= 1'b1;
        dcnt_r[b]  <= 4'd0;
        phase_r[b] <= bcd_pkg::PH_IDLE;
        tick_r[b]  <= 8'd0;
        press_r[b] <= 2'd0;
      end
    end else if (s1_adv) begin
      for (int b = 0; b < NB; b++) begin
        level_r[b] <= level_nxt[b];
        dcnt_r[b]  <= dcnt_nxt[b];
        phase_r[b] <= phase_nxt[b];
        tick_r[b]  <= tick_nxt[b];
        press_r[b] <= press_nxt[b];
      end
    end
  end

  // Result register.
  always_comb begin
    out_data_nxt.event_0 = ev[0];
    out_data_nxt.event_1 = ev[1];
    out_data_nxt.event_2 = ev[2];
    out_data_nxt.event_3 = ev[3];
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/bcd_checker.sv
// Port-level checker for the button click detector, bound to the top level.
`default_nettype none

module bcd_checker (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_ready,
  input wire                    out_valid,
  input wire                    out_ready,
  input bcd_pkg::out_payload_t  out_data
);

  logic out_xfer;
  assign out_xfer = out_valid && out_ready;

  // The result channel is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result keeps its valid and its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A draining result side never blocks the input side.
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while result side drains");

  // A click sequence ends in idle, so the very next tick reports nothing.
  a_click_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && ((out_data.event_0 == bcd_pkg::EV_CLICK) ||
                  (out_data.event_0 == bcd_pkg::EV_DOUBLE))) ##1 out_xfer
    |-> (out_data.event_0 == bcd_pkg::EV_NONE))
    else $error("event right after a click on button 0");

endmodule

bind button_click_detector bcd_checker u_bcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
